// ===== hdl/omni_chassis_wheel_speed_error_macros.svh =====
// Assertion macros shared by the chassis wheel speed error block.
`ifndef OMNI_CHASSIS_WHEEL_SPEED_ERROR_MACROS_SVH
`define OMNI_CHASSIS_WHEEL_SPEED_ERROR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OCWSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wheel speed error check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define OCWSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wheel speed error check failed");

`endif

// ===== hdl/ocwse_pkg.sv =====
`timescale 1ns / 1ps
package ocwse_pkg;
	localparam int XW = 28;
	localparam int ZW = 18;
	localparam int MAGW = 17;
	localparam int LIMW = 15;
	localparam int GAINW = 12;
	localparam int DIV_STEPS = 15;
	localparam int ANGLE_FRAC = 13;
	localparam int MAX_STEPS = 24;
	localparam logic signed [ZW-1:0] ANGLE_PI = 18'sd25736;
	localparam int AW = 3;
	localparam logic [AW-1:0] ADDR_MAX_SPEED = 3'd0;
	localparam logic [AW-1:0] ADDR_ROT_GAIN = 3'd4;

	typedef struct packed {
		logic zero;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic [3:0][15:0] meas;
	} side_t;

	typedef struct packed {
		logic big;
		logic neg;
	} lane_ctl_t;

	function automatic logic signed [ZW-1:0] atan_q13(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0: v = 18'sd6434;
			1: v = 18'sd3798;
			2: v = 18'sd2007;
			3: v = 18'sd1019;
			4: v = 18'sd511;
			5: v = 18'sd256;
			6: v = 18'sd128;
			7: v = 18'sd64;
			8: v = 18'sd32;
			9: v = 18'sd16;
			10: v = 18'sd8;
			11: v = 18'sd4;
			12: v = 18'sd2;
			13: v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction
endpackage

// ===== hdl/omni_chassis_wheel_speed_error.sv =====
`timescale 1ns / 1ps
// Four-wheel omni chassis speed error. One beat is accepted per clock while out_stall is
// low, and each beat yields one result beat. The path runs through the CORDIC vectoring
// chain, one register per iteration, and through the four wheel lanes, each a 15-stage
// restoring divider that scales the wheels when the largest magnitude exceeds
// max_wheel_speed (APB 0x0); rotation_gain sits at APB 0x4. When out_stall holds a result,
// the whole pipeline freezes and in_stall rises in the same cycle.
module omni_chassis_wheel_speed_error #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ocwse_pkg::AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] move_x,
	input logic signed [15:0] move_y,
	input logic signed [15:0] turn_x,
	input logic signed [15:0] turn_y,
	input logic signed [15:0] measured_left_front,
	input logic signed [15:0] measured_right_front,
	input logic signed [15:0] measured_right_back,
	input logic signed [15:0] measured_left_back,
	output logic out_valid,
	input logic out_stall,
	output logic signed [16:0] error_left_front,
	output logic signed [16:0] error_right_front,
	output logic signed [16:0] error_right_back,
	output logic signed [16:0] error_left_back
);
	import ocwse_pkg::*;
	`include "omni_chassis_wheel_speed_error_macros.svh"

	localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
	localparam int LAT = 21 + NS;

	logic [LIMW-1:0] lim_q;
	logic [GAINW-1:0] gain_q;
	logic [LAT-1:0] vld_q;
	logic en, take;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 15'd32767;
			gain_q <= 12'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_MAX_SPEED: lim_q <= pwdata[LIMW-1:0];
				ADDR_ROT_GAIN: gain_q <= pwdata[GAINW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_MAX_SPEED: prdata = 32'(lim_q);
			ADDR_ROT_GAIN: prdata = 32'(gain_q);
			default: prdata = '0;
		endcase
	end

	assign out_valid = vld_q[LAT-1];
	assign en = !(vld_q[LAT-1] && out_stall);
	assign in_stall = vld_q[LAT-1] && out_stall;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], take};
		end
	end

	// Input stage: scale the stick by 256 and fold the left half plane over.
	logic signed [XW-1:0] x_s1, y_s1, x0, y0;
	logic signed [ZW-1:0] z_s1;
	side_t side_s1;

	assign x0 = {{(XW-24){turn_x[15]}}, turn_x, 8'b0};
	assign y0 = {{(XW-24){turn_y[15]}}, turn_y, 8'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			if (turn_x < 0) begin
				x_s1 <= -x0;
				y_s1 <= -y0;
				z_s1 <= (turn_y >= 0) ? ANGLE_PI : -ANGLE_PI;
			end else begin
				x_s1 <= x0;
				y_s1 <= y0;
				z_s1 <= '0;
			end
			side_s1.zero <= (turn_x == 0) && (turn_y == 0);
			side_s1.mx <= move_x;
			side_s1.my <= move_y;
			side_s1.meas <= {measured_left_back, measured_right_back,
				measured_right_front, measured_left_front};
		end
	end

	logic signed [XW-1:0] cx [NS+1];
	logic signed [XW-1:0] cy [NS+1];
	logic signed [ZW-1:0] cz [NS+1];
	side_t side_q [NS];

	assign cx[0] = x_s1;
	assign cy[0] = y_s1;
	assign cz[0] = z_s1;

	for (genvar k = 0; k < NS; k++) begin : g_cordic
		ocwse_cordic_step #(.STEP(k)) u_step (
			.clk(clk), .en(en),
			.x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]),
			.x_s1(cx[k+1]), .y_s1(cy[k+1]), .z_s1(cz[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s1;
			for (int k = 1; k < NS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Angle clamp and rotation product.
	logic signed [ZW-1:0] ang;
	logic signed [30:0] prod_s2;
	side_t side_s2;

	always_comb begin
		if (side_q[NS-1].zero) begin
			ang = '0;
		end else if (cz[NS] > ANGLE_PI) begin
			ang = ANGLE_PI;
		end else if (cz[NS] < -ANGLE_PI) begin
			ang = -ANGLE_PI;
		end else begin
			ang = cz[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 31'($signed({1'b0, gain_q})) * 31'(ang);
			side_s2 <= side_q[NS-1];
		end
	end

	// Wheel mixing.
	logic signed [18:0] rot, mxe, mye;
	logic signed [18:0] w_s3 [4];
	logic [3:0][15:0] meas_s3;

	assign rot = 19'(prod_s2 >>> ANGLE_FRAC);
	assign mxe = 19'(side_s2.mx);
	assign mye = 19'(side_s2.my);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3[0] <= -mxe - mye + rot;
			w_s3[1] <= mxe - mye + rot;
			w_s3[2] <= mxe + mye + rot;
			w_s3[3] <= -mxe + mye + rot;
			meas_s3 <= side_s2.meas;
		end
	end

	// Magnitudes and the largest of them, merged across the four wheels.
	logic [MAGW-1:0] mag [4];
	logic [MAGW-1:0] pk01, pk23, pk;
	logic [MAGW-1:0] mag_s4 [4];
	logic [MAGW-1:0] peak_s4;
	lane_ctl_t ctl_s4 [4];
	logic [3:0][15:0] meas_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mag[k] = w_s3[k][18] ? MAGW'(-w_s3[k]) : MAGW'(w_s3[k]);
		end
		pk01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
		pk23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
		pk = (pk01 > pk23) ? pk01 : pk23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				mag_s4[k] <= mag[k];
				ctl_s4[k].neg <= w_s3[k][18];
				ctl_s4[k].big <= pk > MAGW'(lim_q);
			end
			peak_s4 <= pk;
			meas_s4 <= meas_s3;
		end
	end

	logic signed [16:0] err [4];
	logic signed [16:0] err_q [4];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		ocwse_lane u_lane (
			.clk(clk), .en(en), .lim(lim_q),
			.mag(mag_s4[k]), .peak(peak_s4), .ctl(ctl_s4[k]),
			.meas(meas_s4[k]), .err(err[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				err_q[k] <= err[k];
			end
		end
	end

	assign error_left_front = err_q[0];
	assign error_right_front = err_q[1];
	assign error_right_back = err_q[2];
	assign error_left_back = err_q[3];

	`OCWSE_ASSERT_NOW(a_stall_only_with_result, in_stall, out_valid)
	`OCWSE_ASSERT_NEXT(a_take_enters_pipe, take, vld_q[0])
	`OCWSE_ASSERT_NEXT(a_held_result_stays, out_valid && out_stall, out_valid)
endmodule

// ===== hdl/ocwse_cordic_step.sv =====
`timescale 1ns / 1ps
module ocwse_cordic_step #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic signed [ocwse_pkg::XW-1:0] x_in,
	input logic signed [ocwse_pkg::XW-1:0] y_in,
	input logic signed [ocwse_pkg::ZW-1:0] z_in,
	output logic signed [ocwse_pkg::XW-1:0] x_s1,
	output logic signed [ocwse_pkg::XW-1:0] y_s1,
	output logic signed [ocwse_pkg::ZW-1:0] z_s1
);
	import ocwse_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = atan_q13(STEP);

	logic signed [XW-1:0] sx, sy;

	assign sx = x_in >>> STEP;
	assign sy = y_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_s1 <= x_in + sy;
				y_s1 <= y_in - sx;
				z_s1 <= z_in + ATAN;
			end else begin
				x_s1 <= x_in - sy;
				y_s1 <= y_in + sx;
				z_s1 <= z_in - ATAN;
			end
		end
	end
endmodule

// ===== hdl/ocwse_lane.sv =====
`timescale 1ns / 1ps
module ocwse_lane (
	input logic clk,
	input logic en,
	input logic [ocwse_pkg::LIMW-1:0] lim,
	input logic [ocwse_pkg::MAGW-1:0] mag,
	input logic [ocwse_pkg::MAGW-1:0] peak,
	input ocwse_pkg::lane_ctl_t ctl,
	input logic signed [15:0] meas,
	output logic signed [16:0] err
);
	import ocwse_pkg::*;

	localparam int NW = MAGW + LIMW + 1;

	logic [NW-1:0] prod;
	logic [MAGW-1:0] rem_q [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] low_q [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
	logic [MAGW-1:0] mag_q [DIV_STEPS+1];
	logic [MAGW-1:0] peak_q [DIV_STEPS+1];
	lane_ctl_t ctl_q [DIV_STEPS+1];
	logic signed [15:0] meas_q [DIV_STEPS+1];
	logic [MAGW:0] trial [DIV_STEPS];
	logic ge [DIV_STEPS];
	logic signed [18:0] mag_f, w_f, diff;

	assign prod = NW'(mag) * NW'(lim);

	// Restoring division: one quotient bit per stage, remainder stays below peak.
	always_comb begin
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial[i] = {rem_q[i], low_q[i][DIV_STEPS-1]};
			ge[i] = trial[i] >= {1'b0, peak_q[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= prod[DIV_STEPS +: MAGW];
			low_q[0] <= prod[DIV_STEPS-1:0];
			quo_q[0] <= '0;
			mag_q[0] <= mag;
			peak_q[0] <= peak;
			ctl_q[0] <= ctl;
			meas_q[0] <= meas;
			for (int i = 0; i < DIV_STEPS; i++) begin
				rem_q[i+1] <= ge[i] ? MAGW'(trial[i] - {1'b0, peak_q[i]}) : MAGW'(trial[i]);
				low_q[i+1] <= {low_q[i][DIV_STEPS-2:0], 1'b0};
				quo_q[i+1] <= {quo_q[i][DIV_STEPS-2:0], ge[i]};
				mag_q[i+1] <= mag_q[i];
				peak_q[i+1] <= peak_q[i];
				ctl_q[i+1] <= ctl_q[i];
				meas_q[i+1] <= meas_q[i];
			end
		end
	end

	always_comb begin
		mag_f = ctl_q[DIV_STEPS].big ? 19'(quo_q[DIV_STEPS]) : 19'(mag_q[DIV_STEPS]);
		w_f = ctl_q[DIV_STEPS].neg ? -mag_f : mag_f;
		diff = w_f - 19'(meas_q[DIV_STEPS]);
		err = diff[16:0];
	end
endmodule
